>>> design/fly_camera_integrator_unit_macros.svh
// ---------------------------------------------------------------------------
// fly_camera_integrator_unit_macros
// Assertion macros used by the checker file fci_checker.sv.
// ---------------------------------------------------------------------------
`ifndef FLY_CAMERA_INTEGRATOR_UNIT_MACROS_SVH
`define FLY_CAMERA_INTEGRATOR_UNIT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define FCI_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the cycle after the antecedent.
`define FCI_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/fci_pkg.sv
// ---------------------------------------------------------------------------
// fci_pkg
// Types, constants and tables of the fly camera integrator.
// ---------------------------------------------------------------------------
`default_nettype none

package fci_pkg;

    localparam int ANGLE_BITS    = 16;
    localparam int POS_FRAC_BITS = 16;
    localparam int CORDIC_STEPS  = 16;

    localparam logic [15:0] LOOK_GAIN_RESET  = 16'd8009;
    localparam logic [15:0] MOVE_SPEED_RESET = 16'd1280;

    localparam logic signed [16:0] PITCH_LIMIT = 17'sd16167;
    localparam logic signed [34:0] CORDIC_START = 35'sd652032874;

    typedef enum logic {
        REG_LOOK_GAIN  = 1'b0,
        REG_MOVE_SPEED = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic              look_held;
        logic signed [11:0] mouse_dx;
        logic signed [11:0] mouse_dy;
        logic [5:0]        move_keys;
        logic              fast_key;
        logic [15:0]       frame_time;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] pos_out_x;
        logic signed [31:0] pos_out_y;
        logic signed [31:0] pos_out_z;
        logic signed [15:0] fwd_x;
        logic signed [15:0] fwd_y;
        logic signed [15:0] fwd_z;
    } out_item_t;

    // Control from the sequencer to the CORDIC unit.
    typedef struct packed {
        logic        start;
        logic [31:0] angle;
    } cordic_cmd_t;

    typedef struct packed {
        logic               done;
        logic signed [15:0] sin_q15;
        logic signed [15:0] cos_q15;
    } cordic_rsp_t;

    function automatic logic [31:0] atan_turn(input logic [3:0] i);
        logic [31:0] r;
        begin
            case (i)
                4'd0:  r = 32'h20000000;
                4'd1:  r = 32'h12E4051E;
                4'd2:  r = 32'h09FB385B;
                4'd3:  r = 32'h051111D4;
                4'd4:  r = 32'h028B0D43;
                4'd5:  r = 32'h0145D7E1;
                4'd6:  r = 32'h00A2F61E;
                4'd7:  r = 32'h00517C55;
                4'd8:  r = 32'h0028BE53;
                4'd9:  r = 32'h00145F2F;
                4'd10: r = 32'h000A2F98;
                4'd11: r = 32'h000517CC;
                4'd12: r = 32'h00028BE6;
                4'd13: r = 32'h000145F3;
                4'd14: r = 32'h0000A2FA;
                4'd15: r = 32'h0000517D;
                default: r = 32'h0;
            endcase
            return r;
        end
    endfunction

endpackage

`default_nettype wire

>>> design/fci_cordic.sv
// ---------------------------------------------------------------------------
// fci_cordic
// Iterative rotation CORDIC, one micro-rotation per cycle, Q1.15 results.
// ---------------------------------------------------------------------------
`default_nettype none

module fci_cordic (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire fci_pkg::cordic_cmd_t cmd,
    output fci_pkg::cordic_rsp_t      rsp
);

    typedef enum logic [1:0] {ST_IDLE, ST_ROT, ST_OUT} state_t;

    state_t             state_reg;
    logic [3:0]         iter_reg;
    logic               neg_reg;
    logic signed [34:0] x_reg, y_reg;
    logic signed [33:0] z_reg;
    logic signed [15:0] sin_reg, cos_reg;
    logic               done_reg;

    logic [31:0]        a_adj;
    logic signed [34:0] xs, ys, x_next, y_next, xf, yf;
    logic signed [33:0] z_next, at;

    function automatic logic signed [15:0] to_q15(input logic signed [34:0] v);
        logic signed [35:0] r;
        begin
            r = ($signed({v[34], v}) + 36'sd16384) >>> 15;
            if (r > 36'sd32767) return 16'sd32767;
            if (r < -36'sd32767) return -16'sd32767;
            return r[15:0];
        end
    endfunction

    always_comb begin
        a_adj = (cmd.angle[31:30] == 2'd1 || cmd.angle[31:30] == 2'd2)
              ? cmd.angle + 32'h80000000 : cmd.angle;
        xs = x_reg >>> iter_reg;
        ys = y_reg >>> iter_reg;
        at = $signed({2'b00, fci_pkg::atan_turn(iter_reg)});
        if (!z_reg[33]) begin
            x_next = x_reg - ys;
            y_next = y_reg + xs;
            z_next = z_reg - at;
        end else begin
            x_next = x_reg + ys;
            y_next = y_reg - xs;
            z_next = z_reg + at;
        end
        xf = neg_reg ? -x_reg : x_reg;
        yf = neg_reg ? -y_reg : y_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
            iter_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (cmd.start) begin
                        neg_reg   <= (cmd.angle[31:30] == 2'd1 ||
                                      cmd.angle[31:30] == 2'd2);
                        x_reg     <= fci_pkg::CORDIC_START;
                        y_reg     <= '0;
                        z_reg     <= $signed({{2{a_adj[31]}}, a_adj});
                        iter_reg  <= '0;
                        state_reg <= ST_ROT;
                    end
                end
                ST_ROT: begin
                    x_reg    <= x_next;
                    y_reg    <= y_next;
                    z_reg    <= z_next;
                    iter_reg <= iter_reg + 4'd1;
                    if (iter_reg == 4'(fci_pkg::CORDIC_STEPS - 1)) begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    cos_reg   <= to_q15(xf);
                    sin_reg   <= to_q15(yf);
                    done_reg  <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign rsp.done    = done_reg;
    assign rsp.sin_q15 = sin_reg;
    assign rsp.cos_q15 = cos_reg;

endmodule

`default_nettype wire

>>> design/fly_camera_integrator_unit.sv
// ---------------------------------------------------------------------------
// fly_camera_integrator_unit
// Free-look fly camera: per frame updates view angles and position.
// ---------------------------------------------------------------------------
// Usage: one input beat per frame on s_ (valid/ready) carries the look button,
// mouse deltas, move keys, fast key and frame time. One result beat on m_
// carries the new Q16.16 position and the Q1.15 forward vector.
// Registers look_gain (index 0) and move_speed (index 1) are written through
// cfg_we/cfg_index/cfg_data; the user must write them only while the block
// is idle, which the block itself does not enforce. From input beat to
// result valid come the angle update, two 16-step CORDIC runs in a shared
// rotation unit, then the products through one shared multiplier, the sums
// and the result register.
// One item is in flight at a time; s_ready is high only while the sequencer
// is idle, so a new item is taken only once the previous one has finished.
// If the receiver stalls, the result holds on m_; the next item is computed
// but waits for the result register, and no further beat is taken meanwhile.
// Reset (aresetn low, synchronous) clears angles, position, registers to their
// defaults and empties the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module fly_camera_integrator_unit (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire fci_pkg::in_item_t s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output fci_pkg::out_item_t     m_data,
    input  wire logic              cfg_we,
    input  wire logic              cfg_index,
    input  wire logic [15:0]       cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_DX, ST_DY, ST_ANG, ST_YAW, ST_PITCH,
        ST_FX, ST_FZ, ST_STEP, ST_MUL, ST_SUM, ST_OUT
    } state_t;

    state_t              state_reg;
    fci_pkg::in_item_t   item_reg;
    logic [15:0]         gain_reg, speed_reg;
    logic [15:0]         yaw_reg;
    logic signed [16:0]  pitch_reg;
    logic signed [31:0]  px_reg, py_reg, pz_reg;
    logic signed [15:0]  sy_reg, cy_reg, sp_reg, cp_reg, fx_reg, fz_reg;
    logic signed [34:0]  step_reg;
    logic signed [49:0]  prod_reg;
    logic signed [27:0]  d_reg [6];
    logic [2:0]          k_reg;
    logic                wait_reg;
    logic                m_valid_reg;
    fci_pkg::out_item_t  m_data_reg;

    fci_pkg::cordic_cmd_t ccmd;
    fci_pkg::cordic_rsp_t crsp;

    // Shared multiplier.
    logic signed [34:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [51:0] mul_p;
    logic signed [27:0] rnd_d;
    logic signed [19:0] ang_d;
    logic signed [33:0] dx_sum, dy_sum, dz_sum;
    logic signed [15:0] q15_p;

    fci_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (ccmd),
        .rsp     (crsp)
    );

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        begin
            if (v > 34'sd2147483647) return 32'sh7FFFFFFF;
            if (v < -34'sd2147483648) return 32'sh80000000;
            return v[31:0];
        end
    endfunction

    function automatic logic signed [33:0] sel(input logic p, input logic n,
                                               input logic signed [27:0] d);
        begin
            if (p && !n) return 34'(d);
            if (n && !p) return -34'(d);
            return '0;
        end
    endfunction

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_DX:  begin mul_a = 35'(item_reg.mouse_dx);
                          mul_b = $signed({1'b0, gain_reg}); end
            ST_DY:  begin mul_a = 35'(item_reg.mouse_dy);
                          mul_b = $signed({1'b0, gain_reg}); end
            ST_FX:  begin mul_a = 35'(sy_reg); mul_b = 17'(cp_reg); end
            ST_FZ:  begin mul_a = 35'(cy_reg); mul_b = 17'(cp_reg); end
            ST_STEP: begin mul_a = $signed({19'd0, speed_reg});
                           mul_b = $signed({1'b0, item_reg.frame_time}); end
            ST_MUL: begin
                mul_a = step_reg;
                case (k_reg)
                    3'd0: mul_b = 17'(fx_reg);
                    3'd1: mul_b = 17'(cy_reg);
                    3'd2: mul_b = 17'(sp_reg);
                    3'd3: mul_b = 17'sd32768;
                    3'd4: mul_b = 17'(fz_reg);
                    3'd5: mul_b = -17'(sy_reg);
                    default: mul_b = '0;
                endcase
            end
            default: ;
        endcase
        mul_p = mul_a * mul_b;
        rnd_d = 28'((prod_reg + 50'sd4194304) >>> 23);
        ang_d = 20'((prod_reg + 50'sd128) >>> 8);
        q15_p = 16'((prod_reg + 50'sd16384) >>> 15);
        dx_sum = 34'(px_reg) + sel(item_reg.move_keys[0], item_reg.move_keys[1], d_reg[0])
               + sel(item_reg.move_keys[2], item_reg.move_keys[3], d_reg[1]);
        dy_sum = 34'(py_reg) + sel(item_reg.move_keys[0], item_reg.move_keys[1], d_reg[2])
               + sel(item_reg.move_keys[4], item_reg.move_keys[5], d_reg[3]);
        dz_sum = 34'(pz_reg) + sel(item_reg.move_keys[0], item_reg.move_keys[1], d_reg[4])
               + sel(item_reg.move_keys[2], item_reg.move_keys[3], d_reg[5]);
        ccmd.start = 1'b0;
        ccmd.angle = '0;
        if (state_reg == ST_YAW && !wait_reg) begin
            ccmd.start = 1'b1;
            ccmd.angle = {yaw_reg, 16'd0};
        end else if (state_reg == ST_PITCH && !wait_reg) begin
            ccmd.start = 1'b1;
            ccmd.angle = {pitch_reg[15:0], 16'd0};
        end
    end

    logic [15:0]        ddx_reg;
    logic signed [20:0] pnew;

    assign pnew = 21'(pitch_reg) + 21'(ang_d);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            gain_reg    <= fci_pkg::LOOK_GAIN_RESET;
            speed_reg   <= fci_pkg::MOVE_SPEED_RESET;
            yaw_reg     <= '0;
            pitch_reg   <= '0;
            px_reg      <= '0;
            py_reg      <= '0;
            pz_reg      <= '0;
            m_valid_reg <= 1'b0;
            wait_reg    <= 1'b0;
            k_reg       <= '0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == fci_pkg::REG_LOOK_GAIN) gain_reg <= cfg_data;
                else speed_reg <= cfg_data;
            end
            // A new result loaded in ST_OUT takes the place of the one leaving.
            if (m_valid_reg && m_ready && state_reg != ST_OUT) m_valid_reg <= 1'b0;
            prod_reg <= 50'(mul_p);
            case (state_reg)
                ST_IDLE: if (s_valid) begin
                    item_reg  <= s_data;
                    state_reg <= ST_DX;
                end
                ST_DX: state_reg <= ST_DY;
                ST_DY: begin
                    ddx_reg   <= ang_d[15:0];
                    state_reg <= ST_ANG;
                end
                ST_ANG: begin
                    if (item_reg.look_held) begin
                        yaw_reg <= yaw_reg + ddx_reg;
                        if (pnew > 21'(fci_pkg::PITCH_LIMIT))
                            pitch_reg <= fci_pkg::PITCH_LIMIT;
                        else if (pnew < -21'(fci_pkg::PITCH_LIMIT))
                            pitch_reg <= -fci_pkg::PITCH_LIMIT;
                        else pitch_reg <= pnew[16:0];
                    end
                    state_reg <= ST_YAW;
                end
                ST_YAW: begin
                    if (crsp.done) begin
                        sy_reg <= crsp.sin_q15;
                        cy_reg <= crsp.cos_q15;
                        wait_reg <= 1'b0;
                        state_reg <= ST_PITCH;
                    end else wait_reg <= 1'b1;
                end
                ST_PITCH: begin
                    if (crsp.done) begin
                        sp_reg <= crsp.sin_q15;
                        cp_reg <= crsp.cos_q15;
                        wait_reg <= 1'b0;
                        state_reg <= ST_FX;
                    end else wait_reg <= 1'b1;
                end
                ST_FX: state_reg <= ST_FZ;
                ST_FZ: begin
                    fx_reg <= q15_p;
                    state_reg <= ST_STEP;
                end
                ST_STEP: begin
                    fz_reg <= q15_p;
                    state_reg <= ST_MUL;
                    k_reg <= '0;
                end
                ST_MUL: begin
                    // First cycle latches the step; later ones drain products.
                    if (k_reg == 3'd0 && !wait_reg) begin
                        step_reg <= item_reg.fast_key ? 35'(prod_reg) * 35'sd3
                                                      : 35'(prod_reg);
                        wait_reg <= 1'b1;
                    end else begin
                        if (wait_reg && k_reg != 3'd0) d_reg[k_reg - 3'd1] <= rnd_d;
                        if (k_reg == 3'd6) begin
                            wait_reg  <= 1'b0;
                            state_reg <= ST_SUM;
                        end else k_reg <= k_reg + 3'd1;
                    end
                end
                ST_SUM: begin
                    state_reg <= ST_OUT;
                end
                ST_OUT: if (!m_valid_reg || m_ready) begin
                    px_reg <= sat32(dx_sum);
                    py_reg <= sat32(dy_sum);
                    pz_reg <= sat32(dz_sum);
                    m_data_reg.pos_out_x <= sat32(dx_sum);
                    m_data_reg.pos_out_y <= sat32(dy_sum);
                    m_data_reg.pos_out_z <= sat32(dz_sum);
                    m_data_reg.fwd_x <= fx_reg;
                    m_data_reg.fwd_y <= sp_reg;
                    m_data_reg.fwd_z <= fz_reg;
                    m_valid_reg <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

>>> design/fci_checker.sv
// ---------------------------------------------------------------------------
// fci_checker
// Port-level checks of the fly camera integrator.
// ---------------------------------------------------------------------------
`default_nettype none
`include "fly_camera_integrator_unit_macros.svh"

module fci_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire fci_pkg::out_item_t m_data
);

    `FCI_ASSERT_NEXT(a_busy_after_take, aclk, aresetn, s_valid && s_ready, !s_ready, "ready stayed high after a beat")
    `FCI_ASSERT_NEXT(a_no_instant_result, aclk, aresetn, s_valid && s_ready && !m_valid, !m_valid, "result appeared too early")
    `FCI_ASSERT_NEXT(a_result_holds, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "stalled result changed")

endmodule

bind fly_camera_integrator_unit fci_checker u_fci_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
